// ===== rtl/core/axis_angle_rotation_matrix_macros.svh =====
// Assertion macros used by the checker of the rotation matrix block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

`define AARM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define AARM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/aarm_pkg.sv =====
package aarm_pkg;

    localparam int CORDIC_STAGES_DEF = 18;
    localparam int MAG_W      = 32;
    localparam int ROOT_STEPS = 32;
    localparam int SQ_LAT     = ROOT_STEPS + 2;
    localparam int DIV_STEPS  = 17;
    localparam int SPLIT_LAT  = DIV_STEPS + 1;
    localparam int MOD_STEPS  = 14;
    localparam int MAT_LAT    = 4;
    localparam int U_W        = 18;
    localparam int Q_W        = 17;
    localparam int ANG_W      = 47;
    localparam int CW         = 34;
    localparam int SC_W       = 19;
    localparam int ENT_W      = 18;
    localparam int TS_W       = 24;
    localparam int NF_W       = 16;
    localparam int CFG_W      = 24;

    localparam logic [TS_W-1:0] TIME_STEP_RST  = 24'd16777;
    localparam logic [NF_W-1:0] NORM_FLOOR_RST = 16'd1;

    localparam logic signed [ANG_W-1:0] Q30_PI      = 47'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 47'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 47'sd6746518852;
    localparam logic signed [CW-1:0]    Q30_GAIN    = 34'sd652032874;
    localparam logic signed [CW-1:0]    ROUND_Q14   = 34'sd8192;
    localparam logic signed [SC_W-1:0]  ONE_Q16     = 19'sd65536;
    localparam logic signed [ENT_W-1:0] SAT_HI      = 18'sd131071;
    localparam logic signed [ENT_W-1:0] SAT_LO      = -18'sd131072;
    localparam logic signed [ENT_W-1:0] ENT_ONE     = 18'sd65536;

    typedef enum logic [0:0] {
        CFG_TIME_STEP  = 1'b0,
        CFG_NORM_FLOOR = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } vec_t;

    typedef struct packed {
        logic                tiny;
        logic                neg_cos;
        logic [2:0][U_W-1:0] u;
    } carry_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/aarm_sqrt.sv =====
module aarm_sqrt
    import aarm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  vec_t             vec_in,
    output vec_t             vec_out,
    output logic [MAG_W-1:0] root
);

    logic [2:0][2*MAG_W-1:0] sq_reg;
    vec_t                    vsq_reg;
    logic [2*MAG_W-1:0]      rad_reg  [0:ROOT_STEPS];
    logic [MAG_W+1:0]        rem_reg  [0:ROOT_STEPS];
    logic [MAG_W-1:0]        root_reg [0:ROOT_STEPS];
    vec_t                    vst_reg  [0:ROOT_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= (2*MAG_W)'(vec_in.mag[i]) * (2*MAG_W)'(vec_in.mag[i]);
            end
            vsq_reg     <= vec_in;
            rad_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            vst_reg[0]  <= vsq_reg;
        end
    end

    // One result bit per stage, two radicand bits consumed each time.
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_step
        logic [MAG_W+1:0] r2;
        logic [MAG_W+1:0] t;

        assign r2 = {rem_reg[k][MAG_W-1:0], rad_reg[k][2*MAG_W-1-2*k -: 2]};
        assign t  = {root_reg[k], 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (r2 >= t)
                begin
                    rem_reg[k+1]  <= r2 - t;
                    root_reg[k+1] <= {root_reg[k][MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= r2;
                    root_reg[k+1] <= {root_reg[k][MAG_W-2:0], 1'b0};
                end
                rad_reg[k+1] <= rad_reg[k];
                vst_reg[k+1] <= vst_reg[k];
            end
        end
    end

    assign vec_out = vst_reg[ROOT_STEPS];
    assign root    = root_reg[ROOT_STEPS];

endmodule

// ===== rtl/core/aarm_split.sv =====
module aarm_split
    import aarm_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  vec_t                   vec_in,
    input  logic [MAG_W-1:0]       root,
    input  logic [TS_W-1:0]        time_step,
    input  logic [NF_W-1:0]        norm_floor,
    output carry_t                 carry_out,
    output logic signed [CW-1:0]   ang_out
);

    localparam int LAST = DIV_STEPS - 1;

    logic [2:0][MAG_W-1:0]   r_reg    [0:LAST];
    logic [2:0][Q_W-1:0]     q_reg    [0:LAST];
    logic [MAG_W-1:0]        d_reg    [0:LAST];
    logic [2:0]              neg_reg  [0:LAST];
    logic                    tiny_reg [0:LAST];
    logic                    ncos_reg [0:LAST];
    logic signed [ANG_W-1:0] ang_reg  [0:LAST];
    carry_t                  out_reg;
    logic signed [ANG_W-1:0] aout_reg;

    logic                    tiny0;
    logic [MAG_W+TS_W-1:0]   th0;

    assign tiny0 = (root == '0) || (root < MAG_W'(norm_floor));
    assign th0   = (MAG_W+TS_W)'(root) * (MAG_W+TS_W)'(time_step);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (vec_in.mag[i] >= root)
                begin
                    r_reg[0][i] <= vec_in.mag[i] - root;
                    q_reg[0][i] <= Q_W'(1);
                end
                else
                begin
                    r_reg[0][i] <= vec_in.mag[i];
                    q_reg[0][i] <= '0;
                end
            end
            d_reg[0]    <= root;
            neg_reg[0]  <= vec_in.neg;
            tiny_reg[0] <= tiny0;
            ncos_reg[0] <= 1'b0;
            ang_reg[0]  <= signed'(ANG_W'(th0[MAG_W+TS_W-1:10]));
        end
    end

    for (genvar j = 1; j <= LAST; j++)
    begin : g_stage
        logic signed [ANG_W-1:0] ang_n;
        logic                    ncos_n;

        if (j <= MOD_STEPS)
        begin : g_mod
            localparam logic signed [ANG_W-1:0] STEP = Q30_TWO_PI <<< (MOD_STEPS - j);
            assign ang_n  = (ang_reg[j-1] >= STEP) ? ang_reg[j-1] - STEP : ang_reg[j-1];
            assign ncos_n = 1'b0;
        end
        else if (j == MOD_STEPS + 1)
        begin : g_wrap
            assign ang_n  = (ang_reg[j-1] > Q30_PI) ? ang_reg[j-1] - Q30_TWO_PI
                                                     : ang_reg[j-1];
            assign ncos_n = 1'b0;
        end
        else
        begin : g_fold
            always_comb
            begin
                ang_n  = ang_reg[j-1];
                ncos_n = ncos_reg[j-1];
                if (ang_reg[j-1] > Q30_HALF_PI)
                begin
                    ang_n  = Q30_PI - ang_reg[j-1];
                    ncos_n = 1'b1;
                end
                else if (ang_reg[j-1] < -Q30_HALF_PI)
                begin
                    ang_n  = -Q30_PI - ang_reg[j-1];
                    ncos_n = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ({r_reg[j-1][i], 1'b0} >= {1'b0, d_reg[j-1]})
                    begin
                        r_reg[j][i] <= MAG_W'({r_reg[j-1][i], 1'b0} - {1'b0, d_reg[j-1]});
                        q_reg[j][i] <= {q_reg[j-1][i][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[j][i] <= {r_reg[j-1][i][MAG_W-2:0], 1'b0};
                        q_reg[j][i] <= {q_reg[j-1][i][Q_W-2:0], 1'b0};
                    end
                end
                d_reg[j]    <= d_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                tiny_reg[j] <= tiny_reg[j-1];
                ncos_reg[j] <= ncos_n;
                ang_reg[j]  <= ang_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_reg.u[i] <= neg_reg[LAST][i] ? -U_W'(q_reg[LAST][i])
                                                 : U_W'(q_reg[LAST][i]);
            end
            out_reg.tiny    <= tiny_reg[LAST];
            out_reg.neg_cos <= ncos_reg[LAST];
            aout_reg        <= ang_reg[LAST];
        end
    end

    assign carry_out = out_reg;
    assign ang_out   = aout_reg[CW-1:0];

endmodule

// ===== rtl/core/aarm_cordic.sv =====
module aarm_cordic
    import aarm_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                   clk,
    input  logic                   en,
    input  carry_t                 carry_in,
    input  logic signed [CW-1:0]   ang,
    output carry_t                 carry_out,
    output logic signed [SC_W-1:0] sin16,
    output logic signed [SC_W-1:0] cos1
);

    logic signed [CW-1:0] x_reg [0:STAGES];
    logic signed [CW-1:0] y_reg [0:STAGES];
    logic signed [CW-1:0] z_reg [0:STAGES];
    carry_t               c_reg [0:STAGES];
    carry_t               cout_reg;
    logic signed [SC_W-1:0] s_reg;
    logic signed [SC_W-1:0] c1_reg;
    logic signed [CW-1:0]   s_rnd;
    logic signed [CW-1:0]   c_rnd;
    logic signed [SC_W-1:0] c16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= Q30_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= ang;
            c_reg[0] <= carry_in;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam logic signed [CW-1:0] ATAN = signed'(CW'(atan_q30(5'(i))));
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                c_reg[i+1] <= c_reg[i];
            end
        end
    end

    assign s_rnd = (y_reg[STAGES] + ROUND_Q14) >>> 14;
    assign c_rnd = (x_reg[STAGES] + ROUND_Q14) >>> 14;
    assign c16   = c_rnd[SC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_rnd[SC_W-1:0];
            c1_reg   <= c_reg[STAGES].neg_cos ? ONE_Q16 + c16 : ONE_Q16 - c16;
            cout_reg <= c_reg[STAGES];
        end
    end

    assign carry_out = cout_reg;
    assign sin16     = s_reg;
    assign cos1      = c1_reg;

endmodule

// ===== rtl/core/aarm_matrix.sv =====
module aarm_matrix
    import aarm_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  carry_t                 carry_in,
    input  logic signed [SC_W-1:0] sin16,
    input  logic signed [SC_W-1:0] cos1,
    output logic [8:0][ENT_W-1:0]  ent,
    output logic                   tiny
);

    localparam int P_W = 2 * U_W;
    localparam int S_W = SC_W + U_W;
    localparam int D_W = P_W + 1;
    localparam int M_W = SC_W + D_W;
    localparam int E_W = M_W + 2;

    logic signed [U_W-1:0]  ux, uy, uz;

    logic signed [P_W-1:0]  xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [S_W-1:0]  sx_reg [0:2];
    logic signed [S_W-1:0]  sy_reg [0:2];
    logic signed [S_W-1:0]  sz_reg [0:2];
    logic signed [SC_W-1:0] c1a_reg, c1b_reg;
    logic                   tiny_reg [0:2];

    logic signed [D_W-1:0]  d0_reg, d4_reg, d8_reg, oxy_reg, oxz_reg, oyz_reg;
    logic signed [M_W-1:0]  m0_reg, m4_reg, m8_reg, mxy_reg, mxz_reg, myz_reg;

    logic signed [E_W-1:0]  e [0:8];
    logic [8:0][ENT_W-1:0]  ent_reg;
    logic                   tout_reg;

    assign ux = signed'(carry_in.u[0]);
    assign uy = signed'(carry_in.u[1]);
    assign uz = signed'(carry_in.u[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg      <= P_W'(ux) * P_W'(ux);
            yy_reg      <= P_W'(uy) * P_W'(uy);
            zz_reg      <= P_W'(uz) * P_W'(uz);
            xy_reg      <= P_W'(ux) * P_W'(uy);
            xz_reg      <= P_W'(ux) * P_W'(uz);
            yz_reg      <= P_W'(uy) * P_W'(uz);
            sx_reg[0]   <= S_W'(sin16) * S_W'(ux);
            sy_reg[0]   <= S_W'(sin16) * S_W'(uy);
            sz_reg[0]   <= S_W'(sin16) * S_W'(uz);
            c1a_reg     <= cos1;
            tiny_reg[0] <= carry_in.tiny;

            d0_reg      <= -(D_W'(yy_reg) + D_W'(zz_reg));
            d4_reg      <= -(D_W'(zz_reg) + D_W'(xx_reg));
            d8_reg      <= -(D_W'(yy_reg) + D_W'(xx_reg));
            oxy_reg     <= D_W'(xy_reg);
            oxz_reg     <= D_W'(xz_reg);
            oyz_reg     <= D_W'(yz_reg);
            sx_reg[1]   <= sx_reg[0];
            sy_reg[1]   <= sy_reg[0];
            sz_reg[1]   <= sz_reg[0];
            c1b_reg     <= c1a_reg;
            tiny_reg[1] <= tiny_reg[0];

            m0_reg      <= M_W'(c1b_reg) * M_W'(d0_reg);
            m4_reg      <= M_W'(c1b_reg) * M_W'(d4_reg);
            m8_reg      <= M_W'(c1b_reg) * M_W'(d8_reg);
            mxy_reg     <= M_W'(c1b_reg) * M_W'(oxy_reg);
            mxz_reg     <= M_W'(c1b_reg) * M_W'(oxz_reg);
            myz_reg     <= M_W'(c1b_reg) * M_W'(oyz_reg);
            sx_reg[2]   <= sx_reg[1];
            sy_reg[2]   <= sy_reg[1];
            sz_reg[2]   <= sz_reg[1];
            tiny_reg[2] <= tiny_reg[1];
        end
    end

    always_comb
    begin
        e[0] = (E_W'(1) <<< 48) + E_W'(m0_reg);
        e[1] = E_W'(mxy_reg) - (E_W'(sz_reg[2]) <<< 16);
        e[2] = E_W'(mxz_reg) + (E_W'(sy_reg[2]) <<< 16);
        e[3] = E_W'(mxy_reg) + (E_W'(sz_reg[2]) <<< 16);
        e[4] = (E_W'(1) <<< 48) + E_W'(m4_reg);
        e[5] = E_W'(myz_reg) - (E_W'(sx_reg[2]) <<< 16);
        e[6] = E_W'(mxz_reg) - (E_W'(sy_reg[2]) <<< 16);
        e[7] = E_W'(myz_reg) + (E_W'(sx_reg[2]) <<< 16);
        e[8] = (E_W'(1) <<< 48) + E_W'(m8_reg);
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_ent
        logic signed [E_W-1:0] rnd;
        logic signed [ENT_W-1:0] sat;

        assign rnd = (e[k] + (E_W'(1) <<< 31)) >>> 32;

        always_comb
        begin
            if (tiny_reg[2])
            begin
                sat = (k == 0 || k == 4 || k == 8) ? ENT_ONE : '0;
            end
            else if (rnd > E_W'(SAT_HI))
            begin
                sat = SAT_HI;
            end
            else if (rnd < E_W'(SAT_LO))
            begin
                sat = SAT_LO;
            end
            else
            begin
                sat = rnd[ENT_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ent_reg[k] <= sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tout_reg <= tiny_reg[2];
        end
    end

    assign ent  = ent_reg;
    assign tiny = tout_reg;

endmodule

// ===== rtl/core/axis_angle_rotation_matrix.sv =====
// Throughput: one word per cycle while the skid entry of the output buffer is empty; the square root, divider
// and CORDIC are fully pipelined. A two-entry output buffer lets the pipeline keep filling while an output word waits.
// Reset (rst_n, asynchronous, active low) empties the pipeline and output buffer and
// returns time_step to 16777 and norm_floor to 1.
module axis_angle_rotation_matrix
    import aarm_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [95:0]      s_axis_tdata,   // rate_x, rate_y, rate_z
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [167:0]     m_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic             m_axis_tuser,   // tiny_norm
    input  logic             cfg_wr_en,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int LAT = 1 + SQ_LAT + SPLIT_LAT + CORDIC_STAGES + 2 + MAT_LAT;
    localparam int OUT_W = 9 * ENT_W;

    logic [TS_W-1:0]       time_step_reg;
    logic [NF_W-1:0]       norm_floor_reg;
    logic [LAT-1:0]        vld_reg;
    logic                  en;
    vec_t                  vin_next;
    vec_t                  vin_reg;
    vec_t                  vsq;
    logic [MAG_W-1:0]      root;
    carry_t                csplit;
    logic signed [CW-1:0]  ang;
    carry_t                ccord;
    logic signed [SC_W-1:0] sin16;
    logic signed [SC_W-1:0] cos1;
    logic [8:0][ENT_W-1:0] ent;
    logic                  tiny;
    logic                  take;
    logic                  pv;
    logic [OUT_W-1:0]      out_data_reg;
    logic                  out_tiny_reg;
    logic                  out_v_reg;
    logic [OUT_W-1:0]      skid_data_reg;
    logic                  skid_tiny_reg;
    logic                  skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= TIME_STEP_RST;
            norm_floor_reg <= NORM_FLOOR_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TIME_STEP:  time_step_reg  <= cfg_wdata[TS_W-1:0];
                CFG_NORM_FLOOR: norm_floor_reg <= cfg_wdata[NF_W-1:0];
                default:        time_step_reg  <= time_step_reg;
            endcase
        end
    end

    assign en            = !skid_v_reg;
    assign s_axis_tready = en;
    assign pv            = vld_reg[LAT-1];
    assign take          = out_v_reg && m_axis_tready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vin_next.neg[i] = s_axis_tdata[MAG_W*i + MAG_W-1];
            vin_next.mag[i] = vin_next.neg[i] ? -s_axis_tdata[MAG_W*i +: MAG_W]
                                              : s_axis_tdata[MAG_W*i +: MAG_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vin_reg <= vin_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    aarm_sqrt u_sqrt (
        .clk     (clk),
        .en      (en),
        .vec_in  (vin_reg),
        .vec_out (vsq),
        .root    (root)
    );

    aarm_split u_split (
        .clk        (clk),
        .en         (en),
        .vec_in     (vsq),
        .root       (root),
        .time_step  (time_step_reg),
        .norm_floor (norm_floor_reg),
        .carry_out  (csplit),
        .ang_out    (ang)
    );

    aarm_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .en        (en),
        .carry_in  (csplit),
        .ang       (ang),
        .carry_out (ccord),
        .sin16     (sin16),
        .cos1      (cos1)
    );

    aarm_matrix u_matrix (
        .clk      (clk),
        .en       (en),
        .carry_in (ccord),
        .sin16    (sin16),
        .cos1     (cos1),
        .ent      (ent),
        .tiny     (tiny)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (take || !out_v_reg)
        begin
            out_v_reg  <= skid_v_reg || pv;
            skid_v_reg <= 1'b0;
        end
        else if (pv && en)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !out_v_reg)
        begin
            out_data_reg <= skid_v_reg ? skid_data_reg : ent;
            out_tiny_reg <= skid_v_reg ? skid_tiny_reg : tiny;
        end
        else if (pv && en)
        begin
            skid_data_reg <= ent;
            skid_tiny_reg <= tiny;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {6'b0, out_data_reg};
    assign m_axis_tuser  = out_tiny_reg;

endmodule

// ===== rtl/core/aarm_checker.sv =====
`include "axis_angle_rotation_matrix_macros.svh"

module aarm_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [167:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    `AARM_ASSERT_IMP(a_stall_needs_full_out, !s_axis_tready, m_axis_tvalid, "input stalled with no word waiting")
    `AARM_ASSERT_NXT(a_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped")
    `AARM_ASSERT_NXT(a_data_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled word changed")
    `AARM_ASSERT_IMP(a_tiny_identity, m_axis_tvalid && m_axis_tuser, m_axis_tdata[17:0] == 18'd65536 && m_axis_tdata[35:18] == 18'd0 && m_axis_tdata[53:36] == 18'd0 && m_axis_tdata[71:54] == 18'd0 && m_axis_tdata[89:72] == 18'd65536 && m_axis_tdata[107:90] == 18'd0 && m_axis_tdata[125:108] == 18'd0 && m_axis_tdata[143:126] == 18'd0 && m_axis_tdata[161:144] == 18'd65536, "small norm word is not the identity")
    `AARM_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[167:162] == 6'd0, "padding bits set")

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/axis_angle_rotation_matrix_tb.sv =====
`timescale 1ns / 1ps

module axis_angle_rotation_matrix_tb;
    import aarm_pkg::*;

    typedef struct {
        logic [167:0] entries;
        logic         tiny;
    } matrix_word_t;

    class rotation_scoreboard;
        logic [TS_W-1:0] time_step;
        logic [NF_W-1:0] norm_floor;
        matrix_word_t    pending_matrices[$];
        int              errors;

        function new();
            time_step  = TIME_STEP_RST;
            norm_floor = NORM_FLOOR_RST;
            errors     = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function matrix_word_t rotation_of(logic [95:0] rates);
            matrix_word_t    m;
            longint          w[3];
            longint          u[3];
            longint          kk[9];
            longint          k2[9];
            longint unsigned mag;
            longint unsigned sumsq;
            longint unsigned d;
            longint unsigned th;
            longint          ang;
            longint          x;
            longint          y;
            longint          z;
            longint          dx;
            longint          dy;
            longint          s16;
            longint          c16;
            longint          c1;
            longint          e;
            bit              neg_cos;
            logic [17:0]     ent;
            sumsq   = 0;
            neg_cos = 0;
            for (int i = 0; i < 3; i++)
            begin
                w[i]  = longint'($signed(rates[32*i +: 32]));
                mag   = w[i] < 0 ? -w[i] : w[i];
                sumsq = sumsq + mag * mag;
            end
            d = int_sqrt(sumsq);
            if (d == 0 || d < norm_floor)
            begin
                m.entries = '0;
                m.entries[0 +: 18]   = ENT_ONE;
                m.entries[72 +: 18]  = ENT_ONE;
                m.entries[144 +: 18] = ENT_ONE;
                m.tiny = 1'b1;
                return m;
            end
            for (int i = 0; i < 3; i++)
            begin
                mag  = w[i] < 0 ? -w[i] : w[i];
                u[i] = longint'((mag << 16) / d);
                if (w[i] < 0)
                    u[i] = -u[i];
            end
            th  = d * longint'(time_step);
            ang = longint'((th >> 10) % 64'd6746518852);
            if (ang > 64'sd3373259426)
                ang = ang - 64'sd6746518852;
            if (ang > 64'sd1686629713)
            begin
                ang     = 64'sd3373259426 - ang;
                neg_cos = 1;
            end
            else if (ang < -64'sd1686629713)
            begin
                ang     = -64'sd3373259426 - ang;
                neg_cos = 1;
            end
            x = 652032874;
            y = 0;
            z = ang;
            for (int i = 0; i < CORDIC_STAGES_DEF && i < 32; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(atan_q30(i[4:0]));
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(atan_q30(i[4:0]));
                end
            end
            s16 = (y + 8192) >>> 14;
            c16 = (x + 8192) >>> 14;
            if (neg_cos)
                c16 = -c16;
            c1 = 65536 - c16;
            kk[0] = 0;     kk[1] = -u[2]; kk[2] = u[1];
            kk[3] = u[2];  kk[4] = 0;     kk[5] = -u[0];
            kk[6] = -u[1]; kk[7] = u[0];  kk[8] = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    k2[i*3+j] = kk[i*3] * kk[j] + kk[i*3+1] * kk[3+j]
                              + kk[i*3+2] * kk[6+j];
            for (int i = 0; i < 9; i++)
            begin
                e = s16 * kk[i] * 65536 + c1 * k2[i];
                if (i == 0 || i == 4 || i == 8)
                    e = e + (64'sd1 << 48);
                e = (e + (64'sd1 << 31)) >>> 32;
                if (e > 131071)
                    e = 131071;
                if (e < -131072)
                    e = -131072;
                ent = e[17:0];
                m.entries[18*i +: 18] = ent;
            end
            m.entries[167:162] = '0;
            m.tiny = 1'b0;
            return m;
        endfunction

        function void note_rates(logic [95:0] rates);
            pending_matrices.push_back(rotation_of(rates));
        endfunction

        function void check_matrix(logic [167:0] entries, logic tiny);
            matrix_word_t exp_m;
            if (pending_matrices.size() == 0)
            begin
                $display("%0t: unexpected output word %h", $time, entries);
                errors++;
                return;
            end
            exp_m = pending_matrices.pop_front();
            for (int i = 0; i < 9; i++)
                if (entries[18*i +: 18] !== exp_m.entries[18*i +: 18])
                begin
                    $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                             $signed(exp_m.entries[18*i +: 18]),
                             $signed(entries[18*i +: 18]));
                    errors++;
                end
            if (entries[167:162] !== exp_m.entries[167:162])
            begin
                $display("%0t: padding expected %h actual %h", $time,
                         exp_m.entries[167:162], entries[167:162]);
                errors++;
            end
            if (tiny !== exp_m.tiny)
            begin
                $display("%0t: tiny_norm expected %0b actual %0b", $time, exp_m.tiny, tiny);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [95:0]      s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [167:0]     m_axis_tdata;
    logic             m_axis_tuser;
    logic             cfg_wr_en;
    logic [0:0]       cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    rotation_scoreboard sb = new();
    bit long_hold_req = 0;
    int ready_pct = 100;

    axis_angle_rotation_matrix DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_matrix(m_axis_tdata, m_axis_tuser);

    initial
    begin
        int hold;
        int cnt;
        hold = 0;
        cnt  = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                hold = 400;
            end
            cnt++;
            if (cnt % 250 == 0)
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_TIME_STEP)
            sb.time_step = value[TS_W-1:0];
        else
            sb.norm_floor = value[NF_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_rates(logic [95:0] rates, int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rates;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_rates(rates);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_matrices.size() != 0)
            @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    function automatic logic [31:0] random_rate();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: return $urandom_range(0, 255) - 128;
            3: return $urandom_range(0, 1 << 20) - (1 << 19);
            4: return $urandom_range(0, 1 << 24) - (1 << 23);
            default: return $urandom_range(0, 2) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic random_items(int count);
        int burst;
        int gap;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            gap = 0;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            burst--;
            send_rates({random_rate(), random_rate(), random_rate()},
                       burst == 0 ? gap : 0);
        end
    endtask

    initial
    begin
        logic [31:0] edge_vals[6];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_TIME_STEP;
        cfg_wdata     = '0;
        edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_rates(96'h0, 0);
        for (int i = 0; i < 6; i++)
            send_rates({edge_vals[i], edge_vals[(i + 2) % 6], edge_vals[(i + 4) % 6]}, i % 2);
        send_rates({32'h0, 32'h0, 32'h0001_0000}, 0);
        send_rates({32'h0, 32'h0003_2440, 32'h0}, 0);
        send_rates({32'hFFFC_DBC0, 32'h0, 32'h0}, 2);
        drain();

        write_reg(CFG_NORM_FLOOR, 24'd0);
        write_reg(CFG_TIME_STEP, 24'hFF_FFFF);
        send_rates(96'h0, 0);
        send_rates({32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0);
        send_rates({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
        send_rates({32'h0, 32'h0, 32'h0000_0001}, 0);
        send_rates({32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000}, 0);
        drain();

        write_reg(CFG_NORM_FLOOR, 24'd65535);
        write_reg(CFG_TIME_STEP, 24'd0);
        send_rates({32'h0, 32'h0, 32'h0000_FFFE}, 0);
        send_rates({32'h0, 32'h0, 32'h0000_FFFF}, 0);
        send_rates({32'h0001_0000, 32'h0, 32'h0}, 0);
        drain();

        write_reg(CFG_TIME_STEP, TIME_STEP_RST);
        write_reg(CFG_NORM_FLOOR, NORM_FLOOR_RST);
        long_hold_req = 1;
        random_items(400);
        drain();

        write_reg(CFG_TIME_STEP, 24'hFF_FFFF);
        write_reg(CFG_NORM_FLOOR, 24'd0);
        random_items(400);
        drain();

        write_reg(CFG_TIME_STEP, 24'd1);
        write_reg(CFG_NORM_FLOOR, 24'd65535);
        random_items(300);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_TIME_STEP, CFG_W'($urandom_range(0, 24'hFF_FFFF)));
            write_reg(CFG_NORM_FLOOR, CFG_W'($urandom_range(0, 300)));
            if (p == 2)
                long_hold_req = 1;
            random_items(200);
            drain();
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
